// ===== rtl/core/credit_flow_tx_gate_macros.svh =====
// assertion macros for the credit flow transmit gate
`ifndef CREDIT_FLOW_TX_GATE_MACROS_SVH
`define CREDIT_FLOW_TX_GATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CFTG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CFTG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cftg_pkg.sv =====
// shared constants and types of the credit flow transmit gate
`default_nettype none

package cftg_pkg;

    localparam int MAX_VC    = 8;
    localparam int BURST_MAX = 256;

    localparam int VC_W      = 3;
    localparam int VCN_W     = 4;
    localparam int OP_W      = 3;
    localparam int QUEUED_W  = 16;
    localparam int CNT_W     = 9;
    localparam int VAL_W     = 64;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [OP_W-1:0] OP_TX         = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_VC_LIM = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_PORT   = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_THR    = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_DRAIN  = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_TA     = 3'd5;

    localparam logic [MODE_W-1:0] FC_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] FC_CREDIT = 2'd1;
    localparam logic [MODE_W-1:0] FC_POOL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FC_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VCS    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [VC_W-1:0]     vc;
        logic [QUEUED_W-1:0] queued;
        logic [CNT_W-1:0]    tx_room;
        logic                first_fits;
        logic [VAL_W-1:0]    value;
    } item_t;

    typedef struct packed {
        logic [VC_W-1:0]  vc_out;
        logic [CNT_W-1:0] sent;
        logic [CNT_W-1:0] dropped;
        logic             mark_ta;
        logic [VAL_W-1:0] total_sent;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/cftg_in_stage.sv =====
// input register of the transmit gate
`default_nettype none

module cftg_in_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire cftg_pkg::item_t s_item,
    input  wire logic            advance,
    output logic                 item_valid,
    output cftg_pkg::item_t      item
);
    import cftg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free slot, or the held item leaves this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cftg_core.sv =====
// channel state, configuration registers and burst computation
`default_nettype none

module cftg_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cftg_pkg::cfg_wr_t cfg_wr,
    input  wire logic              fire,
    input  wire cftg_pkg::item_t   item,
    output cftg_pkg::result_t      result
);
    import cftg_pkg::*;

    localparam logic [CNT_W-1:0] BURST_CAP = CNT_W'(BURST_MAX);
    localparam logic [VCN_W-1:0] VC_LIMIT  = VCN_W'(MAX_VC);

    function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    // counts beyond the largest burst all act the same
    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [VAL_W-1:0] x);
        return (x > VAL_W'(BURST_CAP)) ? BURST_CAP : x[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] min_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [MODE_W-1:0] fc_mode_reg;
    logic [CNT_W-1:0]  burst_size_reg;
    logic [VCN_W-1:0]  num_vcs_reg;

    logic [VAL_W-1:0] vc_limit_reg  [MAX_VC];
    logic [VAL_W-1:0] vc_credit_reg [MAX_VC];
    logic [VAL_W-1:0] vc_thr_reg    [MAX_VC];
    logic [VAL_W-1:0] vc_tx_reg     [MAX_VC];
    logic [VAL_W-1:0] vc_drain_reg  [MAX_VC];
    logic [MAX_VC-1:0] vc_ta_reg;
    logic [VAL_W-1:0] port_limit_reg;
    logic [VAL_W-1:0] port_sent_reg;
    logic [VAL_W-1:0] total_reg;
    logic [VAL_W-1:0] total_next;

    logic             vc_ok;
    logic             active;
    logic [CNT_W-1:0] cap_base;
    logic [CNT_W-1:0] cap;
    logic [VAL_W-1:0] pool;
    logic [VAL_W-1:0] infl;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] sent;
    logic [CNT_W-1:0] dropped;
    logic             mark;
    logic             moved;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_mode_reg    <= FC_NONE;
            burst_size_reg <= CNT_W'(32);
            num_vcs_reg    <= VCN_W'(MAX_VC);
        end else if (cfg_wr.we) begin
            case (cfg_wr.index)
                CFG_FC_MODE:    fc_mode_reg    <= cfg_wr.data[MODE_W-1:0];
                CFG_BURST_SIZE: burst_size_reg <= cfg_wr.data[CNT_W-1:0];
                CFG_NUM_VCS:    num_vcs_reg    <= cfg_wr.data[VCN_W-1:0];
                default: ;
            endcase
        end
    end

    assign vc_ok  = {1'b0, item.vc} < VC_LIMIT;
    assign active = (item.op == OP_TX) && vc_ok && ({1'b0, item.vc} < num_vcs_reg);

    always_comb begin
        cap_base = (burst_size_reg > BURST_CAP) ? BURST_CAP : burst_size_reg;
        pool     = sat_sub(port_limit_reg, port_sent_reg);
        infl     = sat_sub(vc_tx_reg[item.vc], vc_drain_reg[item.vc]);
        case (fc_mode_reg)
            FC_CREDIT: cap = min_cnt(cap_base,
                clamp_cnt(sat_sub(vc_limit_reg[item.vc], vc_credit_reg[item.vc])));
            FC_POOL:   cap = min_cnt(cap_base, min_cnt(clamp_cnt(pool),
                clamp_cnt(sat_sub(vc_thr_reg[item.vc], infl))));
            default:   cap = cap_base;
        endcase
        if (!active) begin
            n_cnt = '0;
        end else if (item.queued > QUEUED_W'(cap)) begin
            n_cnt = cap;
        end else begin
            n_cnt = item.queued[CNT_W-1:0];
        end
        sent    = min_cnt(n_cnt, item.tx_room);
        dropped = n_cnt - sent;
        mark    = (n_cnt != '0) && (fc_mode_reg == FC_POOL) && vc_ta_reg[item.vc]
                  && item.first_fits;
        moved   = sent != '0;
        total_next = total_reg + VAL_W'(sent);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_VC; i++) begin
                vc_limit_reg[i]  <= '0;
                vc_credit_reg[i] <= '0;
                vc_thr_reg[i]    <= '0;
                vc_tx_reg[i]     <= '0;
                vc_drain_reg[i]  <= '0;
            end
            vc_ta_reg      <= '0;
            port_limit_reg <= '0;
            port_sent_reg  <= '0;
            total_reg      <= '0;
        end else if (fire) begin
            total_reg <= total_next;
            if (item.op == OP_SET_PORT) begin
                port_limit_reg <= item.value;
            end
            if (moved && fc_mode_reg == FC_POOL) begin
                port_sent_reg <= port_sent_reg + VAL_W'(sent);
            end
            for (int i = 0; i < MAX_VC; i++) begin
                if (vc_ok && item.vc == VC_W'(i)) begin
                    case (item.op)
                        OP_TX: begin
                            if (moved && fc_mode_reg == FC_CREDIT) begin
                                vc_credit_reg[i] <= vc_credit_reg[i] + VAL_W'(sent);
                            end
                            if (moved && fc_mode_reg == FC_POOL) begin
                                vc_tx_reg[i] <= vc_tx_reg[i] + VAL_W'(sent);
                                vc_ta_reg[i] <= 1'b0;
                            end
                        end
                        OP_SET_VC_LIM: vc_limit_reg[i] <= item.value;
                        OP_SET_THR:    vc_thr_reg[i]   <= item.value;
                        OP_SET_DRAIN:  vc_drain_reg[i] <= item.value;
                        OP_SET_TA:     vc_ta_reg[i]    <= item.value[0];
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb begin
        result.vc_out     = item.vc;
        result.sent       = sent;
        result.dropped    = dropped;
        result.mark_ta    = mark;
        result.total_sent = total_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cftg_out_stage.sv =====
// result register of the transmit gate
`default_nettype none

module cftg_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire cftg_pkg::result_t result,
    output logic                   can_load,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cftg_pkg::result_t      m_result
);
    import cftg_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/credit_flow_tx_gate.sv =====
// top level of the credit flow transmit gate
//
//  channel   direction  ports                                         transfer when
//  input     in         s_op s_vc s_queued s_tx_room s_first_fits     s_valid & s_ready
//                       s_value
//  result    out        m_vc_out m_sent m_dropped m_mark_ta           m_valid & m_ready
//                       m_total_sent
//  config    in         cfg_index cfg_data                            cfg_valid & cfg_ready
//
// one item per cycle while m_ready holds: an item is held in the input register, and the
// burst computation and the channel state update happen as it moves to the
// result register, and m_valid rises once the result register is loaded.
// the path that sets the cycle is the in-flight and threshold subtraction chain.
// synchronous active-low reset clears all counters, limits and flags.
// a stalled result holds the result register; the input register still takes
// one more item, then s_ready drops. cfg_ready is always high.
`default_nettype none

`include "credit_flow_tx_gate_macros.svh"

module credit_flow_tx_gate (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [cftg_pkg::OP_W-1:0]      s_op,
    input  wire logic [cftg_pkg::VC_W-1:0]      s_vc,
    input  wire logic [cftg_pkg::QUEUED_W-1:0]  s_queued,
    input  wire logic [cftg_pkg::CNT_W-1:0]     s_tx_room,
    input  wire logic                           s_first_fits,
    input  wire logic [cftg_pkg::VAL_W-1:0]     s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [cftg_pkg::VC_W-1:0]           m_vc_out,
    output logic [cftg_pkg::CNT_W-1:0]          m_sent,
    output logic [cftg_pkg::CNT_W-1:0]          m_dropped,
    output logic                                m_mark_ta,
    output logic [cftg_pkg::VAL_W-1:0]          m_total_sent,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cftg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cftg_pkg::CFG_DAT_W-1:0] cfg_data
);
    import cftg_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t m_result;
    cfg_wr_t cfg_wr;

    assign cfg_ready = 1'b1;

    always_comb begin
        s_item.op         = s_op;
        s_item.vc         = s_vc;
        s_item.queued     = s_queued;
        s_item.tx_room    = s_tx_room;
        s_item.first_fits = s_first_fits;
        s_item.value      = s_value;
        cfg_wr.we         = cfg_valid && cfg_ready;
        cfg_wr.index      = cfg_index;
        cfg_wr.data       = cfg_data;
    end

    assign fire = item_valid && can_load;

    cftg_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    cftg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    cftg_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_vc_out     = m_result.vc_out;
    assign m_sent       = m_result.sent;
    assign m_dropped    = m_result.dropped;
    assign m_mark_ta    = m_result.mark_ta;
    assign m_total_sent = m_result.total_sent;

    // a burst never exceeds the largest burst
    `CFTG_ASSERT_NOW(a_burst_bound, aclk, aresetn, m_valid,
        ({1'b0, m_sent} + {1'b0, m_dropped}) <= (CNT_W + 1)'(BURST_MAX),
        "sent plus dropped exceeds the burst limit")

    // the turnaround mark only goes with a dequeued packet
    `CFTG_ASSERT_NOW(a_mark_moves, aclk, aresetn, m_valid && m_mark_ta,
        (m_sent != '0) || (m_dropped != '0), "turnaround mark with an empty burst")

    // running total grows by exactly the sent count of each new result
    `CFTG_ASSERT_NEXT(a_total_step, aclk, aresetn, fire && m_valid,
        m_total_sent == $past(m_total_sent) + VAL_W'(m_sent),
        "running total out of step with sent count")

    // both registers full and the result stalled: no input is taken
    `CFTG_ASSERT_NOW(a_stall_blocks, aclk, aresetn, item_valid && m_valid && !m_ready,
        !s_ready && !fire, "input taken while both stages are blocked")

endmodule

`default_nettype wire

// ===== tb/sv/credit_flow_tx_gate_checker.sv =====
// transfer monitor, burst grant predictor and result comparison for the credit flow transmit gate
module credit_flow_tx_gate_checker
    import cftg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [OP_W-1:0]      s_op,
    input  wire logic [VC_W-1:0]      s_vc,
    input  wire logic [QUEUED_W-1:0]  s_queued,
    input  wire logic [CNT_W-1:0]     s_tx_room,
    input  wire logic                 s_first_fits,
    input  wire logic [VAL_W-1:0]     s_value,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [VC_W-1:0]      m_vc_out,
    input  wire logic [CNT_W-1:0]     m_sent,
    input  wire logic [CNT_W-1:0]     m_dropped,
    input  wire logic                 m_mark_ta,
    input  wire logic [VAL_W-1:0]     m_total_sent,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output int                        errors,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MODE_W-1:0] mode_r;
    logic [CNT_W-1:0]  burst_r;
    logic [VCN_W-1:0]  nvcs_r;

    logic [VAL_W-1:0] limit_m   [MAX_VC];
    logic [VAL_W-1:0] credit_m  [MAX_VC];
    logic [VAL_W-1:0] thresh_m  [MAX_VC];
    logic [VAL_W-1:0] txcnt_m   [MAX_VC];
    logic [VAL_W-1:0] drained_m [MAX_VC];
    logic             ta_m      [MAX_VC];
    logic [VAL_W-1:0] port_lim_m;
    logic [VAL_W-1:0] port_sent_m;
    logic [VAL_W-1:0] total_m;

    result_t grant_q[$];

    function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [VAL_W-1:0] min64(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // expected result of one item, channel state updated as a side effect
    function automatic result_t grant_burst(input item_t it);
        logic [VAL_W-1:0] cap;
        logic [VAL_W-1:0] pool;
        logic [VAL_W-1:0] infl;
        logic [VAL_W-1:0] n;
        logic [VAL_W-1:0] sent;
        logic [VAL_W-1:0] dropped;
        result_t r;
        r = '0;
        r.vc_out = it.vc;
        sent = '0;
        dropped = '0;
        // a 3-bit channel index is always below MAX_VC
        case (it.op)
            OP_TX: begin
                if ({1'b0, it.vc} < nvcs_r) begin
                    cap = min64(64'(burst_r), 64'(BURST_MAX));
                    if (mode_r == FC_CREDIT) begin
                        cap = min64(cap, sat_sub(limit_m[it.vc], credit_m[it.vc]));
                    end else if (mode_r == FC_POOL) begin
                        pool = sat_sub(port_lim_m, port_sent_m);
                        infl = sat_sub(txcnt_m[it.vc], drained_m[it.vc]);
                        cap = min64(cap, min64(pool, sat_sub(thresh_m[it.vc], infl)));
                    end
                    n = min64(64'(it.queued), cap);
                    if (n != 0) begin
                        sent = min64(n, 64'(it.tx_room));
                        dropped = n - sent;
                        r.mark_ta = (mode_r == FC_POOL) && ta_m[it.vc] && it.first_fits;
                        total_m = total_m + sent;
                        if (sent != 0) begin
                            if (mode_r == FC_CREDIT) begin
                                credit_m[it.vc] = credit_m[it.vc] + sent;
                            end else if (mode_r == FC_POOL) begin
                                port_sent_m = port_sent_m + sent;
                                txcnt_m[it.vc] = txcnt_m[it.vc] + sent;
                                ta_m[it.vc] = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_SET_VC_LIM: limit_m[it.vc] = it.value;
            OP_SET_PORT:   port_lim_m = it.value;
            OP_SET_THR:    thresh_m[it.vc] = it.value;
            OP_SET_DRAIN:  drained_m[it.vc] = it.value;
            OP_SET_TA:     ta_m[it.vc] = it.value[0];
            default: ;
        endcase
        r.sent = sent[CNT_W-1:0];
        r.dropped = dropped[CNT_W-1:0];
        r.total_sent = total_m;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        item_t   it;
        result_t want;
        result_t got;
        if (!aresetn) begin
            mode_r = FC_NONE;
            burst_r = 9'd32;
            nvcs_r = 4'd8;
            for (int i = 0; i < MAX_VC; i++) begin
                limit_m[i] = '0;
                credit_m[i] = '0;
                thresh_m[i] = '0;
                txcnt_m[i] = '0;
                drained_m[i] = '0;
                ta_m[i] = 1'b0;
            end
            port_lim_m = '0;
            port_sent_m = '0;
            total_m = '0;
            grant_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FC_MODE:    mode_r = cfg_data[MODE_W-1:0];
                    CFG_BURST_SIZE: burst_r = cfg_data;
                    CFG_NUM_VCS:    nvcs_r = cfg_data[VCN_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{m_vc_out, m_sent, m_dropped, m_mark_ta, m_total_sent};
                if (grant_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: result transfer with nothing expected, actual vc %0d sent %0d",
                             $time, m_vc_out, m_sent);
                end else begin
                    want = grant_q.pop_front();
                    check_field("vc_out", VAL_W'(want.vc_out), VAL_W'(got.vc_out));
                    check_field("sent", VAL_W'(want.sent), VAL_W'(got.sent));
                    check_field("dropped", VAL_W'(want.dropped), VAL_W'(got.dropped));
                    check_field("mark_ta", VAL_W'(want.mark_ta), VAL_W'(got.mark_ta));
                    check_field("total_sent", want.total_sent, got.total_sent);
                end
            end
            // a result never leaves in the cycle its item arrives, so pop before push
            if (s_valid && s_ready) begin
                it = '{s_op, s_vc, s_queued, s_tx_room, s_first_fits, s_value};
                grant_q.push_back(grant_burst(it));
            end
        end
        pending <= grant_q.size();
    end

endmodule

// ===== tb/sv/credit_flow_tx_gate_tb.sv =====
// top of the credit flow transmit gate testbench: clock, reset, stimulus, stalls and verdict
module credit_flow_tx_gate_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cftg_pkg::*;

    localparam logic [OP_W-1:0]      OP_RSVD6   = 3'd6;
    localparam logic [OP_W-1:0]      OP_RSVD7   = 3'd7;
    localparam logic [MODE_W-1:0]    FC_RSVD    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD   = 2'd3;
    localparam int                   IDLE_LIMIT = 3000;
    localparam int                   HOLD_LEN   = 200;
    localparam int                   PHASES     = 12;
    localparam int                   RAND_ITEMS = 70;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op = '0;
    logic [VC_W-1:0]      s_vc = '0;
    logic [QUEUED_W-1:0]  s_queued = '0;
    logic [CNT_W-1:0]     s_tx_room = '0;
    logic                 s_first_fits = 1'b0;
    logic [VAL_W-1:0]     s_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [VC_W-1:0]      m_vc_out;
    logic [CNT_W-1:0]     m_sent;
    logic [CNT_W-1:0]     m_dropped;
    logic                 m_mark_ta;
    logic [VAL_W-1:0]     m_total_sent;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int fails;
    int owed;
    int burst_left = 0;
    int hold_req = 0;
    int idle_cycles = 0;

    credit_flow_tx_gate dut (.*);

    credit_flow_tx_gate_checker grant_chk (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_op, .s_vc, .s_queued, .s_tx_room, .s_first_fits, .s_value,
        .m_valid, .m_ready, .m_vc_out, .m_sent, .m_dropped, .m_mark_ta, .m_total_sent,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors(fails), .pending(owed)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: stall pattern changes after each random span, long hold on request
    initial begin : receiver
        int stall_mode;
        int span;
        int served;
        int tick;
        served = 0;
        tick = 0;
        forever begin
            stall_mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span) begin
                @(negedge aclk);
                tick++;
                if (hold_req > served) begin
                    served++;
                    m_ready = 1'b0;
                    repeat (HOLD_LEN) @(negedge aclk);
                end
                case (stall_mode)
                    0: m_ready = 1'b1;
                    1: m_ready = ($urandom_range(0, 3) != 0);
                    2: m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = (tick % 3 == 0);
                endcase
            end
        end
    end

    // sender works in bursts; valid stays up inside a burst
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_op = it.op;
        s_vc = it.vc;
        s_queued = it.queued;
        s_tx_room = it.tx_room;
        s_first_fits = it.first_fits;
        s_value = it.value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send(input logic [OP_W-1:0] op, input logic [VC_W-1:0] vc,
                        input logic [QUEUED_W-1:0] queued, input logic [CNT_W-1:0] room,
                        input logic ff, input logic [VAL_W-1:0] value);
        send_item('{op, vc, queued, room, ff, value});
    endtask

    // stop offering and wait until every result has been taken
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (owed != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // unused upper data bits are filled with noise, the block must mask them
    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [CNT_W-1:0] burst,
                              input logic [VCN_W-1:0] nvcs);
        cfg_write(CFG_FC_MODE, {7'($urandom), mode});
        cfg_write(CFG_BURST_SIZE, burst);
        cfg_write(CFG_NUM_VCS, {5'($urandom), nvcs});
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(0, 512));
            4, 5:       return 64'($urandom_range(0, 65535));
            6:          return {$urandom, $urandom};
            7:          return ~64'd0 - 64'($urandom_range(0, 300));
            8:          return '0;
            default:    return ~64'd0;
        endcase
    endfunction

    function automatic logic [QUEUED_W-1:0] pick_queued();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom_range(0, 8));
            3, 4, 5: return 16'($urandom_range(0, 300));
            6, 7:    return 16'($urandom);
            8:       return 16'hFFFF;
            default: return '0;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_room();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 9'($urandom_range(0, 256));
            5:             return 9'($urandom_range(257, 511));
            6:             return '0;
            7:             return 9'd256;
            default:       return 9'($urandom_range(0, 16));
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int r;
        it.vc = 3'($urandom_range(0, 7));
        it.queued = pick_queued();
        it.tx_room = pick_room();
        it.first_fits = 1'($urandom_range(0, 1));
        it.value = pick_value();
        r = $urandom_range(0, 99);
        if (r < 60)      it.op = OP_TX;
        else if (r < 70) it.op = OP_SET_VC_LIM;
        else if (r < 74) it.op = OP_SET_PORT;
        else if (r < 82) it.op = OP_SET_THR;
        else if (r < 90) it.op = OP_SET_DRAIN;
        else if (r < 97) it.op = OP_SET_TA;
        else             it.op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
        if (it.op == OP_SET_TA) it.value = {$urandom, $urandom};
        return it;
    endfunction

    initial begin : stimulus
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  burst;
        logic [VCN_W-1:0]  nvcs;
        int r;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: no flow control, burst of 32, all channels
        send(OP_TX, 3'd0, 16'd0, 9'd256, 1'b0, '0);
        send(OP_TX, 3'd7, 16'hFFFF, 9'd256, 1'b1, ~64'd0);
        send(OP_TX, 3'd3, 16'd40, 9'd10, 1'b0, '0);
        send(OP_TX, 3'd4, 16'd5, 9'd0, 1'b1, '0);
        send(OP_TX, 3'd5, 16'd5, 9'h1FF, 1'b0, '0);
        send(OP_RSVD6, 3'd2, 16'hFFFF, 9'd256, 1'b1, ~64'd0);
        send(OP_RSVD7, 3'd6, 16'd1, 9'd1, 1'b0, 64'h5555_5555_5555_5555);
        wait_idle();
        cfg_write(CFG_RSVD, 9'h1FF);
        set_config(FC_CREDIT, 9'd256, 4'd8);
        send(OP_SET_VC_LIM, 3'd1, '0, '0, 1'b0, 64'd100);
        send(OP_TX, 3'd1, 16'hFFFF, 9'd256, 1'b0, '0);
        // credit used up
        send(OP_TX, 3'd1, 16'hFFFF, 9'd256, 1'b0, '0);
        send(OP_SET_VC_LIM, 3'd2, '0, '0, 1'b0, ~64'd0);
        send(OP_TX, 3'd2, 16'd300, 9'd300, 1'b0, '0);
        wait_idle();
        set_config(FC_POOL, 9'd256, 4'd2);
        send(OP_SET_PORT, 3'd0, '0, '0, 1'b0, 64'd50);
        send(OP_SET_THR, 3'd0, '0, '0, 1'b0, 64'd30);
        send(OP_SET_TA, 3'd0, '0, '0, 1'b0, ~64'd0);
        // marked but nothing accepted by the port, channel stays in turnaround
        send(OP_TX, 3'd0, 16'd5, 9'd0, 1'b1, '0);
        send(OP_TX, 3'd0, 16'd100, 9'd256, 1'b1, '0);
        send(OP_TX, 3'd0, 16'd100, 9'd256, 1'b1, '0);
        send(OP_SET_DRAIN, 3'd0, '0, '0, 1'b0, ~64'd0);
        send(OP_TX, 3'd0, 16'd100, 9'd256, 1'b1, '0);
        send(OP_TX, 3'd5, 16'd10, 9'd256, 1'b1, '0);
        send(OP_SET_TA, 3'd1, '0, '0, 1'b0, 64'd2);
        wait_idle();
        set_config(FC_RSVD, 9'd0, 4'd0);
        send(OP_TX, 3'd0, 16'd10, 9'd10, 1'b1, '0);
        wait_idle();
        set_config(FC_RSVD, 9'd5, 4'd15);
        send(OP_TX, 3'd7, 16'd10, 9'd10, 1'b1, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: set_config(FC_POOL, 9'd256, 4'd8);
                1: set_config(FC_CREDIT, 9'd1, 4'd1);
                2: set_config(FC_NONE, 9'd256, 4'd15);
                3: set_config(FC_RSVD, 9'd511, 4'd0);
                default: begin
                    r = $urandom_range(0, 9);
                    mode = (r < 4) ? FC_POOL : (r < 7) ? FC_CREDIT : (r < 9) ? FC_NONE : FC_RSVD;
                    r = $urandom_range(0, 9);
                    burst = (r == 0) ? 9'd1 : (r == 1) ? 9'd256 :
                            (r == 2) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 64));
                    r = $urandom_range(0, 4);
                    nvcs = (r == 0) ? 4'($urandom_range(0, 15)) : (r == 1) ? 4'd1 : 4'd8;
                    set_config(mode, burst, nvcs);
                end
            endcase
            if (phase == 6) begin
                // long receiver hold while the sender keeps pushing
                hold_req++;
                burst_left = 40;
            end
            send(OP_SET_PORT, 3'($urandom), pick_queued(), pick_room(), 1'($urandom),
                 pick_value());
            for (int v = 0; v < MAX_VC; v++) begin
                send(OP_SET_VC_LIM, 3'(v), pick_queued(), pick_room(), 1'($urandom),
                     pick_value());
                send(OP_SET_THR, 3'(v), pick_queued(), pick_room(), 1'($urandom),
                     pick_value());
                send(OP_SET_TA, 3'(v), pick_queued(), pick_room(), 1'($urandom),
                     {$urandom, $urandom});
            end
            for (int k = 0; k < RAND_ITEMS; k++) begin
                send_item(rand_item());
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        if (fails == 0 && owed == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
